@@ hw/rtl/multilevel_queue_store_core_defines.svh @@
// assertion macros for the multilevel queue store
// needs i_clk and i_rst_n in the module that uses them
`ifndef MULTILEVEL_QUEUE_STORE_CORE_DEFINES_SVH
`define MULTILEVEL_QUEUE_STORE_CORE_DEFINES_SVH

// property holds in the same cycle as its trigger
`define MQS_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (prop)) \
        else $error(msg);

// property holds in the cycle after its trigger
`define MQS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/mqs_pkg.sv @@
// shared types and constants of the multilevel queue store
// no dependencies
package mqs_pkg;

    localparam int NUM_LEVELS_DEF      = 5;
    localparam int SLOTS_PER_QUEUE_DEF = 64;

    localparam int OP_W   = 2;
    localparam int QSEL_W = 3;
    localparam int PID_W  = 6;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_REM = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADQ     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [QSEL_W-1:0] queue_sel;
        logic [PID_W-1:0]  proc_id;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  result_id;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic scan;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic eval_scan;
        logic scan_fin;
    } t_dp_stat;

endpackage

@@ hw/rtl/mqs_ctrl.sv @@
// sequencing state machine of the multilevel queue store
// depends on mqs_pkg
module mqs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  logic             i_out_free,
    output logic             o_publish,
    input  mqs_pkg::t_dp_stat i_stat,
    output mqs_pkg::t_dp_cmd  o_cmd
);
    import mqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_publish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.eval_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to drain
                if (i_out_free) begin
                    o_publish = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule

@@ hw/rtl/mqs_datapath.sv @@
// slot memory, fill counters, scan and shift datapath
// depends on mqs_pkg and the assertion macro header
`include "multilevel_queue_store_core_defines.svh"
module mqs_datapath #(
    parameter int NUM_LEVELS      = mqs_pkg::NUM_LEVELS_DEF,
    parameter int SLOTS_PER_QUEUE = mqs_pkg::SLOTS_PER_QUEUE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mqs_pkg::t_req     i_req,
    input  mqs_pkg::t_dp_cmd  i_cmd,
    output mqs_pkg::t_dp_stat o_stat,
    output mqs_pkg::t_res     o_res
);
    import mqs_pkg::*;

    localparam int FILL_W = $clog2(SLOTS_PER_QUEUE);
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DEPTH  = NUM_LEVELS * SLOTS_PER_QUEUE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [PID_W-1:0]  r_mem [DEPTH];
    logic [PID_W-1:0]  r_rd_data;
    logic [FILL_W-1:0] r_fill [NUM_LEVELS];

    t_req              r_req;
    logic [FILL_W-1:0] r_n;
    logic [ADDR_W-1:0] r_base;
    logic [FILL_W-1:0] r_rd_idx;
    logic [FILL_W-1:0] r_chk_idx;
    logic              r_rd_vld;
    logic              r_found;
    logic [STAT_W-1:0] r_status;
    logic [PID_W-1:0]  r_res_id;

    logic [LVL_W-1:0]  lvl;
    logic              bad;
    logic [FILL_W-1:0] n_cur;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] base_cur;
    logic              enq_ok;
    logic              rd_en;
    logic              proc;
    logic              match;
    logic              shift_we;
    logic              scan_fin;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PID_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;

    assign lvl = r_req.queue_sel[LVL_W-1:0];
    assign bad = ({1'b0, r_req.queue_sel} >= (QSEL_W+1)'(NUM_LEVELS)) ||
                 (r_req.opcode != OP_ENQ && r_req.opcode != OP_DEQ &&
                  r_req.opcode != OP_REM);
    assign n_cur    = bad ? '0 : r_fill[lvl];
    assign full     = (n_cur == FILL_W'(SLOTS_PER_QUEUE - 1));
    assign empty    = (n_cur == '0);
    assign base_cur = ADDR_W'(lvl) * ADDR_W'(SLOTS_PER_QUEUE);
    assign enq_ok   = i_cmd.eval && !bad && (r_req.opcode == OP_ENQ) && !full;

    assign o_stat.eval_scan = !bad && (r_req.opcode != OP_ENQ) && !empty;

    // one read issued per cycle, checked in the cycle after
    assign rd_en    = i_cmd.scan && (r_rd_idx < r_n);
    assign rd_addr  = r_base + ADDR_W'(r_rd_idx);
    assign proc     = i_cmd.scan && r_rd_vld;
    // dequeue takes the head, which is the first slot checked
    assign match    = proc && !r_found &&
                      ((r_req.opcode == OP_DEQ) || (r_rd_data == r_req.proc_id));
    assign shift_we = proc && r_found;
    assign scan_fin = proc && (r_chk_idx == r_n - FILL_W'(1));
    assign o_stat.scan_fin = scan_fin;

    assign wr_en   = enq_ok || shift_we;
    assign wr_addr = enq_ok ? (base_cur + ADDR_W'(n_cur))
                            : (r_base + ADDR_W'(r_chk_idx) - ADDR_W'(1));
    assign wr_data = enq_ok ? r_req.proc_id : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_fill[i] <= '0;
            end
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            // no read is issued during evaluation, so this also clears it there
            r_rd_vld <= rd_en;
            if (i_cmd.eval) begin
                r_found  <= 1'b0;
            end else if (match) begin
                r_found <= 1'b1;
            end
            if (enq_ok) begin
                r_fill[lvl] <= n_cur + FILL_W'(1);
            end else if (scan_fin && (r_found || match)) begin
                r_fill[lvl] <= r_n - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.eval) begin
            r_n      <= n_cur;
            r_base   <= base_cur;
            r_rd_idx <= '0;
            r_res_id <= '0;
            if (bad) begin
                r_status <= ST_BADQ;
            end else if (r_req.opcode == OP_ENQ) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end
        end else begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + FILL_W'(1);
            end
            if (match) begin
                r_res_id <= r_rd_data;
            end
            if (scan_fin && !(r_found || match)) begin
                r_status <= ST_NOTFOUND;
            end
        end
        r_chk_idx <= r_rd_idx;
    end

    assign o_res.status    = r_status;
    assign o_res.result_id = r_res_id;

    `MQS_ASSERT_NOW(a_shift_after_hit, shift_we, r_found && !enq_ok, "shift without a hit")
    `MQS_ASSERT_NOW(a_read_live, rd_en, r_rd_idx < r_n, "read past the live entries")
    `MQS_ASSERT_NEXT(a_enq_fill, enq_ok, r_fill[$past(lvl)] == $past(n_cur) + FILL_W'(1),
        "fill count not bumped on enqueue")

endmodule

@@ hw/rtl/multilevel_queue_store_core.sv @@
// Multilevel queue store: one request at a time, one result per request.
// Enqueue and the bad-queue, full and empty results go from evaluation straight to the done state;
// dequeue and remove otherwise scan the addressed queue through the slot memory's
// single read port, one slot per cycle.
// The result enters the output register from the done state once that register is free.
// Synchronous active-low reset clears fill counts and control; slots stay unwritten.
module multilevel_queue_store_core #(
    parameter int NUM_LEVELS      = mqs_pkg::NUM_LEVELS_DEF,
    parameter int SLOTS_PER_QUEUE = mqs_pkg::SLOTS_PER_QUEUE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  mqs_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output mqs_pkg::t_res o_res
);
    import mqs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_res     dp_res;
    logic     publish;
    logic     out_free;
    logic     r_out_vld;
    t_res     r_out;

    assign out_free = !r_out_vld || !i_res_stall;

    mqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_out_free  (out_free),
        .o_publish   (publish),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mqs_datapath #(
        .NUM_LEVELS      (NUM_LEVELS),
        .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (dp_res)
    );

    // output register decouples the result from the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (publish) begin
            r_out_vld <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_out <= dp_res;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule
